>>> src/rcv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ribbon CV package
// Shared types, state codes, reciprocal and polynomial constants of the
// ribbon CV block.
// ----------------------------------------------------------------------------
package rcv_pkg;

	typedef enum logic [4:0] {
		S_IDLE, S_DX_GO, S_DX_WT, S_DY_GO, S_DY_WT, S_DU_GO, S_DU_WT,
		S_PM, S_DR_GO, S_DR_WT, S_DS_GO, S_DS_WT, S_CV, S_CU2, S_SQ_GO,
		S_SQ_WT, S_SN1, S_SN2, S_SN3, S_SN4, S_SN5, S_SN6, S_SN7, S_SN8,
		S_VOL, S_VCA, S_FIN
	} state_t;

	typedef enum logic [1:0] {
		CFG_BASE_OCTAVE  = 2'd0,
		CFG_OCTAVE_COUNT = 2'd1,
		CFG_CURVE_MODE   = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		CURVE_LINEAR   = 3'd0,
		CURVE_CIRCULAR = 3'd1,
		CURVE_COSINE   = 3'd2,
		CURVE_SINE     = 3'd3,
		CURVE_GATE     = 3'd4
	} curve_t;

	typedef enum logic [2:0] {
		DIV_BY_100,
		DIV_BY_500,
		DIV_BY_10,
		DIV_BY_12,
		DIV_BY_24
	} div_sel_t;

	// Rounded-up reciprocals, exact for every dividend below 2^32.
	localparam logic [33:0] RCP_100 = 34'd5497558139;
	localparam logic [33:0] RCP_500 = 34'd4398046512;
	localparam logic [33:0] RCP_10  = 34'd6871947674;
	localparam logic [33:0] RCP_12  = 34'd5726623062;

	localparam logic [33:0] SC1 = 34'd1686629713;
	localparam logic [33:0] SC3 = 34'd693598667;
	localparam logic [33:0] SC5 = 34'd85569306;
	localparam logic [33:0] SC7 = 34'd5026994;
	localparam logic [33:0] SC9 = 34'd172272;

endpackage

>>> src/rcv_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ribbon CV input channel
// Valid/ready channel carrying one sample tick word.
// ----------------------------------------------------------------------------
interface rcv_in_if;
	logic               valid;
	logic               ready;
	logic [15:0]        pad_x;
	logic [15:0]        pad_y;
	logic [5:0]         key_index;
	logic               dragging;
	logic               snap_button;
	logic               ext_present;
	logic signed [16:0] ext_sample;

	modport source (output valid, pad_x, pad_y, key_index, dragging, snap_button,
		ext_present, ext_sample, input ready);
	modport sink (input valid, pad_x, pad_y, key_index, dragging, snap_button,
		ext_present, ext_sample, output ready);
endinterface

>>> src/rcv_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ribbon CV output channel
// Valid/ready channel carrying one result word per tick.
// ----------------------------------------------------------------------------
interface rcv_out_if;
	logic               valid;
	logic               ready;
	logic signed [16:0] pitch_cv;
	logic signed [16:0] raw_pitch_cv;
	logic [15:0]        volume_cv;
	logic               gate_on;
	logic signed [16:0] vca_out;
	logic               snap_light;

	modport source (output valid, pitch_cv, raw_pitch_cv, volume_cv, gate_on,
		vca_out, snap_light, input ready);
	modport sink (input valid, pitch_cv, raw_pitch_cv, volume_cv, gate_on,
		vca_out, snap_light, output ready);
endinterface

>>> src/rcv_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ribbon CV constant divider
// Reciprocal table and quotient select for the divisions by constants that
// run on the shared multiplier.
// ----------------------------------------------------------------------------
module rcv_div (
	input  rcv_pkg::div_sel_t  sel,
	input  logic signed [67:0] prod,
	output logic signed [33:0] recip,
	output logic [33:0]        quo
);
	import rcv_pkg::*;

	always_comb begin
		case (sel)
			DIV_BY_100: begin
				recip = RCP_100;
				quo   = 34'(prod >>> 39);
			end
			DIV_BY_500: begin
				recip = RCP_500;
				quo   = 34'(prod >>> 41);
			end
			DIV_BY_10: begin
				recip = RCP_10;
				quo   = 34'(prod >>> 36);
			end
			DIV_BY_24: begin
				recip = RCP_12;
				quo   = 34'(prod >>> 37);
			end
			default: begin
				recip = RCP_12;
				quo   = 34'(prod >>> 36);
			end
		endcase
	end
endmodule

>>> src/rcv_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ribbon CV square root
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module rcv_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [33:0] v,
	output logic        busy,
	output logic [16:0] root
);
	logic [33:0] v_q;
	logic [33:0] r_q;
	logic [33:0] bit_q;
	logic [33:0] sum;

	assign sum = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
		end else if (start) begin
			bit_q <= 34'd1 << 32;
		end else if (bit_q != 34'd0) begin
			bit_q <= bit_q >> 2;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= v;
			r_q <= '0;
		end else if (bit_q != 34'd0) begin
			if (v_q >= sum) begin
				v_q <= v_q - sum;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
		end
	end

	assign busy = (bit_q != 34'd0);
	assign root = r_q[16:0];
endmodule

>>> src/rcv_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ribbon CV multiplier
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module rcv_mul (
	input  logic               clk,
	input  logic               en,
	input  logic signed [33:0] a,
	input  logic signed [33:0] b,
	output logic signed [67:0] p
);
	logic signed [67:0] p_q;

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= a * b;
		end
	end

	assign p = p_q;
endmodule

>>> src/ribbon_cv_slew_and_curve.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ribbon CV slew and curve
// Per tick ribbon controller: slewed position and height, pitch, curved
// volume, gate and a VCA on an external sample.
// ----------------------------------------------------------------------------
// Usage:
// One word on in_ch is one sample tick. The block then runs a sequencer over
// a shared multiplier and a square root unit, and in_ch.ready stays low until
// the result is loaded into the output register. Divisions by constants are
// reciprocal multiplies on the shared multiplier. Sine and cosine mode add
// polynomial multiplies and circular mode the 17-step root to the work of
// linear or gate mode. The next word is accepted in the cycle after the load.
// Results leave through out_ch from an output register; the next tick is
// accepted and computed while a result waits, and only the final load waits
// for the receiver when it stalls.
// Configuration is written through cfg_we, cfg_index and cfg_data by the user
// only while the block is idle; the block does not enforce this. Reset clears
// the smoothed position and height, the snap mode and the button history, and
// sets base octave 0, one octave and the gate curve.
// ----------------------------------------------------------------------------
module ribbon_cv_slew_and_curve #(
	parameter int VOLT_FRAC_BITS = 12
) (
	input  logic       clk,
	input  logic       arst_n,
	rcv_in_if.sink     in_ch,
	rcv_out_if.source  out_ch,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [3:0] cfg_data
);
	import rcv_pkg::*;

	localparam logic [23:0] TEN_S   = 24'(10 * (64'd1 << VOLT_FRAC_BITS));
	localparam logic [20:0] Y_MAX   = 21'(10 * (64'd1 << VOLT_FRAC_BITS));
	localparam logic [35:0] GATE_TH = 36'((64'd1 << VOLT_FRAC_BITS) << 16);
	localparam logic signed [34:0] S_VAL = 35'(64'd1 << VOLT_FRAC_BITS);
	localparam logic signed [34:0] OFF_24S = 35'(24 * (64'd1 << VOLT_FRAC_BITS));
	localparam logic signed [23:0] S_V24 = 24'(64'd1 << VOLT_FRAC_BITS);

	state_t state_q, state_d;

	logic signed [3:0] base_q;
	logic [1:0]        octs_q;
	logic [2:0]        curve_q;

	logic [31:0] sx_q, sy_q, tx_q, ty_q;
	logic        snap_q, btn_q;
	logic [5:0]  key_q;
	logic        drag_q, pres_q;
	logic signed [16:0] ext_q;
	logic [16:0] u_q, g_q;
	logic [30:0] x2_q;
	logic signed [16:0] raw_q, sh_q;
	logic [15:0] vol_q;
	logic [33:0] ds_num_q;

	logic               out_valid_q;
	logic signed [16:0] pitch_o_q, raw_o_q, vca_o_q;
	logic [15:0]        vol_o_q;
	logic               gate_o_q, snap_o_q;

	div_sel_t           dsel;
	logic signed [33:0] drecip;
	logic [33:0]        dquo;
	logic               sq_start, sq_busy;
	logic [16:0]        sq_root;
	logic               m_en;
	logic signed [33:0] m_a, m_b;
	logic signed [67:0] m_p;

	logic        accept, load_out;
	logic        sel_y;
	logic [31:0] cur, tgt, slewed;
	logic signed [33:0] diff;
	logic [33:0] mag;
	logic signed [23:0] base_v;
	logic signed [34:0] vsh;
	logic signed [34:0] ds_pre;
	logic [33:0] xval;
	logic signed [33:0] pn;
	logic [37:0] rsin;
	logic [16:0] s_val;
	logic [35:0] y10;
	logic [5:0]  n12;
	logic [5:0]  key_sat;
	logic [20:0] py_sat;
	logic signed [67:0] rnd;

	rcv_div u_div (.sel(dsel), .prod(m_p), .recip(drecip), .quo(dquo));
	rcv_sqrt u_sqrt (.clk(clk), .arst_n(arst_n), .start(sq_start),
		.v((34'd1 << 32) - m_p[33:0]), .busy(sq_busy), .root(sq_root));
	rcv_mul u_mul (.clk(clk), .en(m_en), .a(m_a), .b(m_b), .p(m_p));

	assign accept   = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE);
	assign load_out = (state_q == S_FIN) && (!out_valid_q || out_ch.ready);

	assign sel_y = (state_q == S_DY_GO) || (state_q == S_DY_WT);
	assign cur   = sel_y ? sy_q : sx_q;
	assign tgt   = sel_y ? ty_q : tx_q;
	assign diff  = $signed({2'b0, tgt}) - $signed({2'b0, cur});
	assign mag   = diff[33] ? 34'(-diff) : 34'(diff);
	assign slewed = (dquo == '0) ? tgt :
		(diff[33] ? cur - dquo[31:0] : cur + dquo[31:0]);

	assign base_v = $signed({{20{base_q[3]}}, base_q}) <<< VOLT_FRAC_BITS;
	assign vsh    = $signed(35'(m_p >>> 31)) + 35'sd12 - S_VAL;
	assign ds_pre = snap_q ?
		$signed(35'({key_q, 1'b1}) << VOLT_FRAC_BITS) + 35'sd12 : vsh;

	assign xval  = {17'd0, u_q} << 14;
	assign pn    = 34'(m_p >>> 30);
	assign rsin  = 38'(m_p >>> 30) + 38'd8192;
	assign s_val = (rsin[37:14] > 24'd65536) ? 17'd65536 : rsin[30:14];
	assign y10   = {1'b0, sy_q, 3'b0} + {3'b0, sy_q, 1'b0};
	assign rnd   = m_p + 68'sd32768;

	assign n12     = (octs_q == 2'd0) ? 6'd12 : 6'(octs_q) * 6'd12;
	assign key_sat = (in_ch.key_index > n12) ? n12 : in_ch.key_index;
	assign py_sat  = !in_ch.dragging ? 21'd0 :
		(({5'd0, in_ch.pad_y} > Y_MAX) ? Y_MAX : {5'd0, in_ch.pad_y});

	always_comb begin
		case (state_q)
			S_DX_GO, S_DX_WT: dsel = DIV_BY_100;
			S_DY_GO, S_DY_WT: dsel = DIV_BY_500;
			S_DU_GO, S_DU_WT: dsel = DIV_BY_10;
			S_DR_GO, S_DR_WT: dsel = DIV_BY_12;
			S_DS_GO, S_DS_WT: dsel = DIV_BY_24;
			default:          dsel = DIV_BY_12;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		sq_start = 1'b0;
		m_en     = 1'b0;
		m_a      = '0;
		m_b      = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_DX_GO;
			end
			S_DX_GO: begin
				m_en = 1'b1;
				m_a  = $signed(mag);
				m_b  = drecip;
				state_d = S_DX_WT;
			end
			S_DX_WT: begin
				state_d = S_DY_GO;
			end
			S_DY_GO: begin
				m_en = 1'b1;
				m_a  = $signed(mag);
				m_b  = drecip;
				state_d = S_DY_WT;
			end
			S_DY_WT: begin
				state_d = S_DU_GO;
			end
			S_DU_GO: begin
				m_en = 1'b1;
				m_a  = $signed({2'b0, sy_q >> VOLT_FRAC_BITS});
				m_b  = drecip;
				state_d = S_DU_WT;
			end
			S_DU_WT: begin
				state_d = S_PM;
			end
			S_PM: begin
				m_en = 1'b1;
				m_a  = $signed({2'b0, sx_q});
				m_b  = $signed(34'((6'd12 * 6'((octs_q == 2'd0) ? 2'd1 : octs_q) + 6'd1))
					<< VOLT_FRAC_BITS);
				state_d = S_DR_GO;
			end
			S_DR_GO: begin
				m_en = 1'b1;
				m_a  = $signed(snap_q ? (34'(key_q) << VOLT_FRAC_BITS) + 34'd6 :
					34'(m_p >>> 32) + 34'd6);
				m_b  = drecip;
				state_d = S_DR_WT;
			end
			S_DR_WT: begin
				state_d = S_DS_GO;
			end
			S_DS_GO: begin
				m_en = 1'b1;
				m_a  = $signed(ds_num_q);
				m_b  = drecip;
				state_d = S_DS_WT;
			end
			S_DS_WT: begin
				state_d = S_CV;
			end
			S_CV: begin
				case (curve_q)
					CURVE_CIRCULAR: state_d = S_CU2;
					CURVE_COSINE:   state_d = S_SN1;
					CURVE_SINE:     state_d = S_SN1;
					default:        state_d = S_VOL;
				endcase
			end
			S_CU2: begin
				m_en = 1'b1;
				m_a  = $signed({17'd0, u_q});
				m_b  = $signed({17'd0, u_q});
				state_d = S_SQ_GO;
			end
			S_SQ_GO: begin
				sq_start = 1'b1;
				state_d  = S_SQ_WT;
			end
			S_SQ_WT: begin
				if (!sq_busy) state_d = S_VOL;
			end
			S_SN1: begin
				m_en = 1'b1;
				m_a  = $signed(xval);
				m_b  = $signed(xval);
				state_d = S_SN2;
			end
			S_SN2: begin
				m_en = 1'b1;
				m_a  = pn;
				m_b  = $signed(SC9);
				state_d = S_SN3;
			end
			S_SN3: begin
				m_en = 1'b1;
				m_a  = $signed({3'd0, x2_q});
				m_b  = $signed(SC7) - pn;
				state_d = S_SN4;
			end
			S_SN4: begin
				m_en = 1'b1;
				m_a  = $signed({3'd0, x2_q});
				m_b  = $signed(SC5) - pn;
				state_d = S_SN5;
			end
			S_SN5: begin
				m_en = 1'b1;
				m_a  = $signed({3'd0, x2_q});
				m_b  = $signed(SC3) - pn;
				state_d = S_SN6;
			end
			S_SN6: begin
				m_en = 1'b1;
				m_a  = $signed(xval);
				m_b  = $signed(SC1) - pn;
				state_d = S_SN7;
			end
			S_SN7: begin
				m_en = 1'b1;
				m_a  = $signed({17'd0, s_val});
				m_b  = $signed({17'd0, s_val});
				state_d = (curve_q == CURVE_SINE) ? S_VOL : S_SN8;
			end
			S_SN8: begin
				state_d = S_VOL;
			end
			S_VOL: begin
				m_en = 1'b1;
				m_a  = $signed({17'd0, g_q});
				m_b  = $signed({10'd0, TEN_S});
				state_d = S_VCA;
			end
			S_VCA: begin
				m_en = 1'b1;
				m_a  = 34'(ext_q);
				m_b  = $signed({17'd0, g_q});
				state_d = S_FIN;
			end
			S_FIN: begin
				if (load_out) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			octs_q  <= 2'd1;
			curve_q <= CURVE_GATE;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BASE_OCTAVE:  base_q  <= cfg_data;
				CFG_OCTAVE_COUNT: octs_q  <= cfg_data[1:0];
				CFG_CURVE_MODE:   curve_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q   <= '0;
			sy_q   <= '0;
			snap_q <= 1'b0;
			btn_q  <= 1'b0;
		end else begin
			if (accept) begin
				if (in_ch.snap_button && !btn_q) snap_q <= !snap_q;
				btn_q <= in_ch.snap_button;
			end
			if (state_q == S_DX_WT) sx_q <= slewed;
			if (state_q == S_DY_WT) sy_q <= slewed;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tx_q   <= {in_ch.pad_x, 16'd0};
			ty_q   <= 32'(py_sat) << 16;
			key_q  <= key_sat;
			drag_q <= in_ch.dragging;
			pres_q <= in_ch.ext_present;
			ext_q  <= in_ch.ext_sample;
		end
		case (state_q)
			S_DU_WT: begin
				u_q <= (dquo > 34'd65536) ? 17'd65536 : dquo[16:0];
			end
			S_DR_GO: begin
				ds_num_q <= 34'(ds_pre + OFF_24S);
			end
			S_DR_WT: begin
				raw_q <= 17'(base_v + $signed({1'b0, dquo[22:0]}));
			end
			S_DS_WT: begin
				sh_q <= 17'(base_v + $signed({1'b0, dquo[22:0]}) - S_V24);
			end
			S_CV: begin
				if (curve_q == CURVE_GATE) g_q <= (y10 > GATE_TH) ? 17'd65536 : 17'd0;
				else g_q <= u_q;
			end
			S_SQ_WT: begin
				g_q <= 17'd65536 - sq_root;
			end
			S_SN2: begin
				x2_q <= 31'(m_p >>> 30);
			end
			S_SN7: begin
				g_q <= s_val;
			end
			S_SN8: begin
				g_q <= rnd[32:16];
			end
			S_VCA: begin
				vol_q <= rnd[31:16];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			pitch_o_q <= sh_q;
			raw_o_q   <= raw_q;
			vol_o_q   <= vol_q;
			gate_o_q  <= drag_q;
			snap_o_q  <= snap_q;
			vca_o_q   <= (drag_q && pres_q) ? rnd[32:16] : 17'sd0;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.pitch_cv     = pitch_o_q;
	assign out_ch.raw_pitch_cv = raw_o_q;
	assign out_ch.volume_cv    = vol_o_q;
	assign out_ch.gate_on      = gate_o_q;
	assign out_ch.vca_out      = vca_o_q;
	assign out_ch.snap_light   = snap_o_q;

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ch.ready) |=> (out_valid_q && $stable(raw_o_q)))
		else $error("waiting result word changed or dropped");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !accept) |=> (state_q == S_IDLE))
		else $error("sequencer left idle without a word");

	a_load_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FIN))
		else $error("result loaded outside the final state");

	a_sqrt_only_circular: assert property (@(posedge clk) disable iff (!arst_n)
		sq_start |-> (curve_q == CURVE_CIRCULAR))
		else $error("square root started outside circular mode");
endmodule

>>> verif/tb_ribbon_cv_slew_and_curve.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ribbon CV slew and curve testbench
// Drives sample tick words into the ribbon CV block and predicts each result
// word from its own model of the slew, the snap toggle, the pitch map and the
// five volume curves. Every result is checked field by field, in order. The
// run sweeps many register settings, the extremes among them, and uses random
// idling on both channels, a long receiver stall and drained pauses.
// ----------------------------------------------------------------------------
module tb_ribbon_cv_slew_and_curve;
	import rcv_pkg::*;

	typedef struct {
		logic [15:0] pad_x;
		logic [15:0] pad_y;
		logic [5:0]  key_index;
		logic        dragging;
		logic        snap_button;
		logic        ext_present;
		logic [16:0] ext_sample;
	} tick_t;

	typedef struct {
		logic [16:0] pitch_cv;
		logic [16:0] raw_pitch_cv;
		logic [15:0] volume_cv;
		logic        gate_on;
		logic [16:0] vca_out;
		logic        snap_light;
	} cv_word_t;

	localparam longint VSCALE = 64'd4096;
	localparam longint TWO32  = 64'h1_0000_0000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [3:0] cfg_data;

	rcv_in_if  in_ch ();
	rcv_out_if out_ch ();

	ribbon_cv_slew_and_curve uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	tick_t    tick_q[$];
	cv_word_t cv_expect_q[$];
	int       mismatches = 0;
	int       words_in = 0;
	int       words_out = 0;
	int       phases_run = 0;
	bit       in_taken = 0;
	bit       send_hold = 0;
	bit       calm = 0;
	int       rx_hold_cycles = 0;

	// Model state and registers.
	logic [31:0] pos_x, pos_y;
	logic        snap_on, btn_prev;
	logic [3:0]  base_oct;
	logic [1:0]  oct_cnt;
	logic [2:0]  curve_sel;

	// Gesture generator state.
	int g_x, g_y, g_key, g_run;
	bit g_drag;

	initial clk = 0;
	always #5 clk = ~clk;

	initial begin
		#50_000_000;
		$display("FAIL ribbon_cv_slew_and_curve");
		$finish;
	end

	function automatic longint floor_quot(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b != 0) && (a < 0))
			q = q - 1;
		return q;
	endfunction

	function automatic logic [31:0] slew_to(logic [31:0] cur, longint tgt, longint dv);
		longint st, nxt;
		st = (tgt - longint'(cur)) / dv;
		nxt = (st == 0) ? tgt : longint'(cur) + st;
		return nxt[31:0];
	endfunction

	function automatic longint unsigned int_root(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint unsigned sine_quarter(longint unsigned u);
		longint unsigned x, x2, p, r;
		x = u << 14;
		x2 = (x * x) >> 30;
		p = 64'(SC7) - ((x2 * 64'(SC9)) >> 30);
		p = 64'(SC5) - ((x2 * p) >> 30);
		p = 64'(SC3) - ((x2 * p) >> 30);
		p = 64'(SC1) - ((x2 * p) >> 30);
		r = (x * p) >> 30;
		r = (r + (64'd1 << 13)) >> 14;
		return (r > 65536) ? 64'd65536 : r;
	endfunction

	function automatic longint unsigned curve_gain_of(logic [31:0] y);
		longint unsigned u, s;
		u = longint'(y) / (10 * VSCALE);
		if (u > 65536)
			u = 65536;
		case (curve_sel)
			CURVE_CIRCULAR: return 65536 - int_root((64'd1 << 32) - u * u);
			CURVE_COSINE: begin
				s = sine_quarter(u);
				return (s * s + 32768) >> 16;
			end
			CURVE_SINE: return sine_quarter(u);
			CURVE_GATE: return (longint'(y) * 10 > (VSCALE << 16)) ? 64'd65536 : 64'd0;
			default: return u;
		endcase
	endfunction

	function automatic cv_word_t predict_cv(tick_t t);
		cv_word_t w;
		longint py, key, ext, n, base, raw, shifted, vca, prod, vol;
		longint unsigned g;
		py = longint'(t.pad_y);
		key = longint'(t.key_index);
		ext = longint'($signed(t.ext_sample));
		n = (oct_cnt == 2'd0) ? 64'sd1 : longint'(oct_cnt);
		base = longint'($signed(base_oct)) * VSCALE;
		vca = 0;
		if (t.snap_button && !btn_prev)
			snap_on = !snap_on;
		btn_prev = t.snap_button;
		if (!t.dragging)
			py = 0;
		if (py > 10 * VSCALE)
			py = 10 * VSCALE;
		pos_x = slew_to(pos_x, longint'(t.pad_x) << 16, 100);
		pos_y = slew_to(pos_y, py * 65536, 500);
		if (key > n * 12)
			key = n * 12;
		if (snap_on) begin
			raw = base + (key * VSCALE + 6) / 12;
			shifted = base + ((2 * key + 1) * VSCALE + 12) / 24;
		end else begin
			prod = longint'(pos_x) * (12 * n + 1) * VSCALE;
			raw = base + (prod + 6 * TWO32) / (12 * TWO32);
			shifted = base + floor_quot(2 * prod - VSCALE * TWO32 + 12 * TWO32, 24 * TWO32);
		end
		g = curve_gain_of(pos_y);
		if (t.dragging && t.ext_present)
			vca = floor_quot(ext * longint'(g) + 32768, 65536);
		vol = longint'((g * 64'(10 * VSCALE) + 32768) >> 16);
		w.pitch_cv = shifted[16:0];
		w.raw_pitch_cv = raw[16:0];
		w.volume_cv = vol[15:0];
		w.gate_on = t.dragging;
		w.vca_out = vca[16:0];
		w.snap_light = snap_on;
		return w;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		mismatches++;
		$display("mismatch on word %0d: %s got %h expected %h", words_out, what, got, want);
	endtask

	// Sender: a word stays offered until it is taken.
	always @(negedge clk) begin
		if (arst_n && (!in_ch.valid || in_taken)) begin
			if (tick_q.size() > 0 && !send_hold && (calm || $urandom_range(99) >= 22)) begin
				in_ch.valid <= 1'b1;
				in_ch.pad_x <= tick_q[0].pad_x;
				in_ch.pad_y <= tick_q[0].pad_y;
				in_ch.key_index <= tick_q[0].key_index;
				in_ch.dragging <= tick_q[0].dragging;
				in_ch.snap_button <= tick_q[0].snap_button;
				in_ch.ext_present <= tick_q[0].ext_present;
				in_ch.ext_sample <= tick_q[0].ext_sample;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		tick_t t;
		if (in_ch.valid && in_ch.ready) begin
			t.pad_x = in_ch.pad_x;
			t.pad_y = in_ch.pad_y;
			t.key_index = in_ch.key_index;
			t.dragging = in_ch.dragging;
			t.snap_button = in_ch.snap_button;
			t.ext_present = in_ch.ext_present;
			t.ext_sample = in_ch.ext_sample;
			cv_expect_q.push_back(predict_cv(t));
			void'(tick_q.pop_front());
			words_in++;
			in_taken = 1;
		end else begin
			in_taken = 0;
		end
	end

	// Receiver, with its own count for the long hold-off.
	always @(negedge clk) begin
		if (rx_hold_cycles > 0) begin
			rx_hold_cycles <= rx_hold_cycles - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= calm || ($urandom_range(99) >= 22);
		end
	end

	always @(posedge clk) begin
		cv_word_t e;
		if (out_ch.valid && out_ch.ready) begin
			if (cv_expect_q.size() == 0) begin
				mismatches++;
				$display("unexpected result word %0d", words_out);
			end else begin
				e = cv_expect_q.pop_front();
				if (out_ch.pitch_cv !== e.pitch_cv)
					report_mismatch("pitch_cv", out_ch.pitch_cv, e.pitch_cv);
				if (out_ch.raw_pitch_cv !== e.raw_pitch_cv)
					report_mismatch("raw_pitch_cv", out_ch.raw_pitch_cv, e.raw_pitch_cv);
				if (out_ch.volume_cv !== e.volume_cv)
					report_mismatch("volume_cv", out_ch.volume_cv, e.volume_cv);
				if (out_ch.gate_on !== e.gate_on)
					report_mismatch("gate_on", out_ch.gate_on, e.gate_on);
				if (out_ch.vca_out !== e.vca_out)
					report_mismatch("vca_out", out_ch.vca_out, e.vca_out);
				if (out_ch.snap_light !== e.snap_light)
					report_mismatch("snap_light", out_ch.snap_light, e.snap_light);
			end
			words_out++;
		end
	end

	task automatic add_tick(int x, int y, int k, bit d, bit b, bit p, int e);
		tick_t t;
		t.pad_x = 16'(x);
		t.pad_y = 16'(y);
		t.key_index = 6'(k);
		t.dragging = d;
		t.snap_button = b;
		t.ext_present = p;
		t.ext_sample = 17'(e);
		tick_q.push_back(t);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [3:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_BASE_OCTAVE: base_oct = val;
			CFG_OCTAVE_COUNT: oct_cnt = val[1:0];
			default: curve_sel = val[2:0];
		endcase
	endtask

	task automatic drain();
		wait (tick_q.size() == 0 && cv_expect_q.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	// Mostly held gestures with random content, some noise words.
	task automatic add_random_tick();
		int x, y, k, e;
		if (g_run == 0) begin
			g_run = $urandom_range(200, 10);
			g_drag = ($urandom_range(99) < 75);
			g_x = $urandom_range(65535);
			g_y = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(40960);
			g_key = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(37);
		end
		g_run--;
		x = g_x;
		y = g_y;
		k = g_key;
		if ($urandom_range(9) == 0) begin
			x = $urandom_range(65535);
			y = $urandom_range(65535);
			k = $urandom_range(63);
		end
		e = ($urandom_range(4) == 0) ? $urandom_range(131071) : $urandom_range(98304) - 49152;
		add_tick(x, y, k, g_drag ^ ($urandom_range(49) == 0), $urandom_range(15) == 0,
			$urandom_range(99) < 85, e);
	endtask

	initial begin
		int base_l[12] = '{0, -5, 4, -8, 7, -1, 2, 3, -5, 4, 0, -3};
		int cnt_l[12]  = '{1, 3, 3, 0, 2, 1, 3, 1, 1, 2, 3, 2};
		int mode_l[12] = '{CURVE_LINEAR, CURVE_CIRCULAR, CURVE_COSINE, CURVE_SINE,
			CURVE_GATE, 5, 6, 7, CURVE_COSINE, CURVE_SINE, CURVE_CIRCULAR, CURVE_LINEAR};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_BASE_OCTAVE;
		cfg_data = 4'd0;
		in_ch.valid = 1'b0;
		in_ch.pad_x = '0;
		in_ch.pad_y = '0;
		in_ch.key_index = '0;
		in_ch.dragging = 1'b0;
		in_ch.snap_button = 1'b0;
		in_ch.ext_present = 1'b0;
		in_ch.ext_sample = '0;
		out_ch.ready = 1'b0;
		pos_x = 0;
		pos_y = 0;
		snap_on = 0;
		btn_prev = 0;
		base_oct = 4'd0;
		oct_cnt = 2'd1;
		curve_sel = CURVE_GATE;
		g_run = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed words under the reset settings.
		add_tick(0, 0, 0, 0, 0, 0, 0);
		add_tick(65535, 40960, 37, 1, 0, 1, 49152);
		add_tick(65535, 65535, 63, 1, 0, 1, -49152);
		add_tick(65535, 65535, 63, 1, 1, 1, 65535);
		add_tick(65535, 65535, 12, 1, 1, 1, -65536);
		add_tick(32768, 40960, 13, 1, 0, 1, 1);
		add_tick(32768, 40960, 63, 1, 1, 0, 49152);
		add_tick(0, 40960, 0, 0, 0, 1, -1);
		add_tick(1, 1, 1, 1, 0, 1, 131071);
		add_tick(65535, 40960, 6, 1, 1, 1, 12345);
		add_tick(65535, 40960, 6, 1, 0, 1, -12345);
		for (int i = 0; i < 10; i++)
			add_tick(65535, 40960, 37, 1, 0, 1, 49152);
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			write_reg(CFG_BASE_OCTAVE, 4'(base_l[ph]));
			write_reg(CFG_OCTAVE_COUNT, 4'(cnt_l[ph]));
			write_reg(CFG_CURVE_MODE, 4'(mode_l[ph]));
			calm = (ph == 5);
			for (int i = 0; i < 135; i++)
				add_random_tick();
			if (ph == 2) begin
				@(posedge clk);
				rx_hold_cycles = 1500;
			end
			if (ph == 7) begin
				wait (tick_q.size() < 70);
				send_hold = 1;
				wait (cv_expect_q.size() == 0);
				send_hold = 0;
			end
			drain();
			phases_run++;
		end
		calm = 0;

		repeat (300) @(posedge clk);
		if (cv_expect_q.size() != 0) begin
			mismatches++;
			$display("%0d expected words never arrived", cv_expect_q.size());
		end
		$display("Run covered %0d tick words and %0d result words over %0d register settings,",
			words_in, words_out, phases_run + 1);
		$display("all five curves and unused selectors, snap toggling and channel stalls.");
		if (mismatches == 0) begin
			$display("PASS ribbon_cv_slew_and_curve");
		end else begin
			$display("FAIL ribbon_cv_slew_and_curve");
		end
		$finish;
	end

endmodule
